/* rtl/core/nrdiv_pkg.sv */
// ----------------------------------------------------------------------------
// nrdiv_pkg
// Shared constants and word types for the non-restoring unsigned divider.
// ----------------------------------------------------------------------------
package nrdiv_pkg;

   localparam int DATA_W        = 32;
   localparam int WIDTH_DEFAULT = 32;

   typedef struct packed {
      logic [DATA_W-1:0] dividend;
      logic [DATA_W-1:0] divisor;
   } req_word_type;

   typedef struct packed {
      logic [DATA_W-1:0] quotient;
      logic [DATA_W-1:0] remainder;
      logic              divide_by_zero;
   } rsp_word_type;

endpackage

/* rtl/core/nrdiv_req_if.sv */
// ----------------------------------------------------------------------------
// nrdiv_req_if
// Valid/ready channel that carries one dividend and divisor word.
// ----------------------------------------------------------------------------
interface nrdiv_req_if;

   logic                    valid;
   logic                    ready;
   nrdiv_pkg::req_word_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);

endinterface

/* rtl/core/nrdiv_rsp_if.sv */
// ----------------------------------------------------------------------------
// nrdiv_rsp_if
// Valid/ready channel that carries one quotient and remainder word.
// ----------------------------------------------------------------------------
interface nrdiv_rsp_if;

   logic                    valid;
   logic                    ready;
   nrdiv_pkg::rsp_word_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);

endinterface

/* rtl/core/nrdiv_stage.sv */
// ----------------------------------------------------------------------------
// nrdiv_stage
// One registered non-restoring step: shift, add or subtract, new quotient bit.
// ----------------------------------------------------------------------------
module nrdiv_stage #(
   parameter int WIDTH = nrdiv_pkg::WIDTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             prev_valid,
   input  logic [WIDTH:0]   prev_a,
   input  logic [WIDTH-1:0] prev_q,
   input  logic [WIDTH-1:0] prev_m,
   input  logic             prev_zero,
   output logic             next_valid,
   output logic [WIDTH:0]   next_a,
   output logic [WIDTH-1:0] next_q,
   output logic [WIDTH-1:0] next_m,
   output logic             next_zero
);

   logic             valid_ff;
   logic [WIDTH:0]   a_ff;
   logic [WIDTH:0]   a_in;
   logic [WIDTH:0]   shifted;
   logic [WIDTH-1:0] q_ff;
   logic [WIDTH-1:0] q_in;
   logic [WIDTH-1:0] m_ff;
   logic             zero_ff;

   always_comb begin
      shifted = {prev_a[WIDTH-1:0], prev_q[WIDTH-1]};
      if (prev_a[WIDTH]) begin
         a_in = shifted + {1'b0, prev_m};
      end else begin
         a_in = shifted - {1'b0, prev_m};
      end
      q_in = {prev_q[WIDTH-2:0], ~a_in[WIDTH]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff    <= a_in;
         q_ff    <= q_in;
         m_ff    <= prev_m;
         zero_ff <= prev_zero;
      end
   end

   assign next_valid = valid_ff;
   assign next_a     = a_ff;
   assign next_q     = q_ff;
   assign next_m     = m_ff;
   assign next_zero  = zero_ff;

endmodule

/* rtl/core/nonrestoring_unsigned_divider_core.sv */
// ----------------------------------------------------------------------------
// nonrestoring_unsigned_divider_core
// Fully pipelined unsigned non-restoring divider, one step per stage.
// ----------------------------------------------------------------------------
// The req_if channel takes one word holding a dividend and a divisor; the
// rsp_if channel returns one word holding the quotient, the remainder and a
// divide-by-zero flag. Only the low WIDTH bits of each input are used.
// The pipeline has WIDTH step stages, each one WIDTH+1 bit add or subtract,
// followed by a correction stage that is also the output register.
// A new word is accepted every cycle while the output is taken.
// When the receiver stalls with a word waiting, the whole pipeline holds and
// req_if.ready drops in the same cycle; nothing is lost or repeated.
// A zero divisor yields an all-ones quotient, the dividend as remainder and
// the flag set. Synchronous reset empties the pipeline; stored data is kept
// but marked invalid.
// ----------------------------------------------------------------------------
module nonrestoring_unsigned_divider_core #(
   parameter int WIDTH = nrdiv_pkg::WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   nrdiv_req_if.sink   req_if,
   nrdiv_rsp_if.source rsp_if
);

   localparam int DW = nrdiv_pkg::DATA_W;

   logic             en;
   logic             valid_s [WIDTH+1];
   logic [WIDTH:0]   a_s     [WIDTH+1];
   logic [WIDTH-1:0] q_s     [WIDTH+1];
   logic [WIDTH-1:0] m_s     [WIDTH+1];
   logic             zero_s  [WIDTH+1];

   logic             rsp_valid_ff;
   logic [WIDTH-1:0] quot_ff;
   logic [WIDTH-1:0] rem_ff;
   logic [WIDTH:0]   rem_in;
   logic             zero_ff;

   assign en           = ~(rsp_valid_ff & ~rsp_if.ready);
   assign req_if.ready = en;

   assign valid_s[0] = req_if.valid;
   assign a_s[0]     = '0;
   assign q_s[0]     = WIDTH'(req_if.data.dividend);
   assign m_s[0]     = WIDTH'(req_if.data.divisor);
   assign zero_s[0]  = (WIDTH'(req_if.data.divisor) == '0);

   for (genvar i = 0; i < WIDTH; i++) begin : g_step
      nrdiv_stage #(
         .WIDTH(WIDTH)
      ) u_stage (
         .clock      (clock),
         .reset      (reset),
         .en         (en),
         .prev_valid (valid_s[i]),
         .prev_a     (a_s[i]),
         .prev_q     (q_s[i]),
         .prev_m     (m_s[i]),
         .prev_zero  (zero_s[i]),
         .next_valid (valid_s[i+1]),
         .next_a     (a_s[i+1]),
         .next_q     (q_s[i+1]),
         .next_m     (m_s[i+1]),
         .next_zero  (zero_s[i+1])
      );
   end

   always_comb begin
      if (a_s[WIDTH][WIDTH]) begin
         rem_in = a_s[WIDTH] + {1'b0, m_s[WIDTH]};
      end else begin
         rem_in = a_s[WIDTH];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= valid_s[WIDTH];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quot_ff <= q_s[WIDTH];
         rem_ff  <= rem_in[WIDTH-1:0];
         zero_ff <= zero_s[WIDTH];
      end
   end

   assign rsp_if.valid               = rsp_valid_ff;
   assign rsp_if.data.quotient       = DW'(quot_ff);
   assign rsp_if.data.remainder      = DW'(rem_ff);
   assign rsp_if.data.divide_by_zero = zero_ff;

`ifndef SYNTH
   // A zero divisor gives an all-ones quotient.
   a_zero_quot : assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.data.divide_by_zero) |->
         (rsp_if.data.quotient == DW'({WIDTH{1'b1}})))
      else $error("divide by zero did not give an all-ones quotient");

   // No word enters while the output word is held by the receiver.
   a_stall_block : assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.ready) |-> !(req_if.valid && req_if.ready))
      else $error("word accepted during an output stall");

   // A valid word in the last step stage reaches the output on an advance.
   a_last_stage : assert property (@(posedge clock) disable iff (reset)
      (en && valid_s[WIDTH]) |=> rsp_if.valid)
      else $error("word from the last step stage was lost");
`endif

endmodule
